### rtl/acb_pkg.sv
// Package for the alpha icon blitter: geometry constants, register codes,
// blend masks and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package acb_pkg;

    // Framebuffer and icon geometry
    localparam int unsigned FB_WIDTH      = 256;
    localparam int unsigned FB_HEIGHT     = 256;
    localparam int unsigned MAX_ICON_SIZE = 64;
    localparam int unsigned FB_DEPTH      = FB_WIDTH * FB_HEIGHT;
    localparam int unsigned FB_AW         = $clog2(FB_DEPTH);

    // Field and register widths
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned RGB_W    = 24;
    localparam int unsigned ALPHA_W  = 8;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned SIZE_W   = 7;
    localparam int unsigned STRIDE_W = 9;
    localparam int unsigned HEIGHT_W = 9;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned REGIDX_W = 3;

    // Derived widths for the destination math
    localparam int unsigned CNT_W   = $clog2(MAX_ICON_SIZE);
    localparam int unsigned ES_W    = $clog2(MAX_ICON_SIZE + 1);
    localparam int unsigned SW_W    = $clog2(FB_WIDTH + 1);
    localparam int unsigned SH_W    = $clog2(FB_HEIGHT + 1);
    localparam int unsigned COORD_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int unsigned CMP_W0  = (COORD_W > SW_W) ? COORD_W : SW_W;
    localparam int unsigned CMP_W   = (CMP_W0 > SH_W) ? CMP_W0 : SH_W;
    localparam int unsigned A_W     = $clog2(FB_HEIGHT) + SW_W + 1;

    // Register indexes
    localparam logic [REGIDX_W-1:0] REG_ICON_LEFT     = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_ICON_TOP      = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_ICON_SIZE     = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_LINE_STRIDE   = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [SIZE_W-1:0]   ICON_SIZE_RST     = 7'd32;
    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST   = 9'd256;
    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 9'd256;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BLIT = 1'b1;

    // Alpha codes and blend masks
    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [WORD_W-1:0]  RB_MASK      = 32'h00FF00FF;
    localparam logic [WORD_W-1:0]  G_MASK       = 32'h0000FF00;

    typedef struct packed {
        logic [POS_W-1:0]    icon_left;
        logic [POS_W-1:0]    icon_top;
        logic [SIZE_W-1:0]   icon_size;
        logic [STRIDE_W-1:0] line_stride;
        logic [HEIGHT_W-1:0] screen_height;
    } t_cfg;

    typedef struct packed {
        logic              in_frame;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_dest;

endpackage

### rtl/acb_cfg_regs.sv
// APB-style configuration registers of the alpha icon blitter.
// Depends on acb_pkg for register codes, widths and the t_cfg struct.
`timescale 1ns / 1ps

module acb_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acb_pkg::PADDR_W-1:0]  paddr,
    input  logic [acb_pkg::PDATA_W-1:0]  pwdata,
    output logic [acb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output acb_pkg::t_cfg                o_cfg
);

    logic [acb_pkg::REGIDX_W-1:0] reg_idx;
    logic                         wr_en;
    acb_pkg::t_cfg                r_cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[acb_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.icon_left     <= '0;
            r_cfg.icon_top      <= '0;
            r_cfg.icon_size     <= acb_pkg::ICON_SIZE_RST;
            r_cfg.line_stride   <= acb_pkg::LINE_STRIDE_RST;
            r_cfg.screen_height <= acb_pkg::SCREEN_HEIGHT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                acb_pkg::REG_ICON_LEFT: begin
                    r_cfg.icon_left <= pwdata[acb_pkg::POS_W-1:0];
                end
                acb_pkg::REG_ICON_TOP: begin
                    r_cfg.icon_top <= pwdata[acb_pkg::POS_W-1:0];
                end
                acb_pkg::REG_ICON_SIZE: begin
                    r_cfg.icon_size <= pwdata[acb_pkg::SIZE_W-1:0];
                end
                acb_pkg::REG_LINE_STRIDE: begin
                    r_cfg.line_stride <= pwdata[acb_pkg::STRIDE_W-1:0];
                end
                acb_pkg::REG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= pwdata[acb_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            acb_pkg::REG_ICON_LEFT:     prdata = acb_pkg::PDATA_W'(r_cfg.icon_left);
            acb_pkg::REG_ICON_TOP:      prdata = acb_pkg::PDATA_W'(r_cfg.icon_top);
            acb_pkg::REG_ICON_SIZE:     prdata = acb_pkg::PDATA_W'(r_cfg.icon_size);
            acb_pkg::REG_LINE_STRIDE:   prdata = acb_pkg::PDATA_W'(r_cfg.line_stride);
            acb_pkg::REG_SCREEN_HEIGHT: prdata = acb_pkg::PDATA_W'(r_cfg.screen_height);
            default:                    prdata = '0;
        endcase
    end

endmodule

### rtl/acb_dest_gen.sv
// Icon row/column counter and destination address with edge clipping.
// Depends on acb_pkg for geometry constants and the t_cfg / t_dest structs.
`timescale 1ns / 1ps

module acb_dest_gen (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  acb_pkg::t_cfg  i_cfg,
    input  logic           i_advance,
    output acb_pkg::t_dest o_dest
);

    logic [acb_pkg::CNT_W-1:0]   r_row, n_row;
    logic [acb_pkg::CNT_W-1:0]   r_col, n_col;
    logic [acb_pkg::CNT_W-1:0]   row_e, col_e;
    logic [acb_pkg::ES_W-1:0]    es;
    logic [acb_pkg::SW_W-1:0]    stride;
    logic [acb_pkg::SH_W-1:0]    height;
    logic signed [acb_pkg::COORD_W-1:0] dx, dy;
    logic [acb_pkg::COORD_W-1:0] dxu, dyu;
    logic [acb_pkg::A_W-1:0]     lin_addr;
    logic                        visible;
    logic                        last;

    always_comb begin
        // Saturate the size, stride and height into their legal ranges
        if (i_cfg.icon_size == '0) begin
            es = acb_pkg::ES_W'(1);
        end else if (i_cfg.icon_size > acb_pkg::MAX_ICON_SIZE) begin
            es = acb_pkg::ES_W'(acb_pkg::MAX_ICON_SIZE);
        end else begin
            es = acb_pkg::ES_W'(i_cfg.icon_size);
        end
        if (i_cfg.line_stride == '0) begin
            stride = acb_pkg::SW_W'(1);
        end else if (i_cfg.line_stride > acb_pkg::FB_WIDTH) begin
            stride = acb_pkg::SW_W'(acb_pkg::FB_WIDTH);
        end else begin
            stride = acb_pkg::SW_W'(i_cfg.line_stride);
        end
        if (i_cfg.screen_height == '0) begin
            height = acb_pkg::SH_W'(1);
        end else if (i_cfg.screen_height > acb_pkg::FB_HEIGHT) begin
            height = acb_pkg::SH_W'(acb_pkg::FB_HEIGHT);
        end else begin
            height = acb_pkg::SH_W'(i_cfg.screen_height);
        end

        // Restart the counter if the icon shrank below it
        if (acb_pkg::ES_W'(r_row) >= es || acb_pkg::ES_W'(r_col) >= es) begin
            row_e = '0;
            col_e = '0;
        end else begin
            row_e = r_row;
            col_e = r_col;
        end

        dx  = acb_pkg::COORD_W'($signed(i_cfg.icon_left)) + acb_pkg::COORD_W'(col_e);
        dy  = acb_pkg::COORD_W'($signed(i_cfg.icon_top)) + acb_pkg::COORD_W'(row_e);
        dxu = dx;
        dyu = dy;

        visible = !dx[acb_pkg::COORD_W-1] && !dy[acb_pkg::COORD_W-1]
               && (acb_pkg::CMP_W'(dxu) < acb_pkg::CMP_W'(stride))
               && (acb_pkg::CMP_W'(dyu) < acb_pkg::CMP_W'(height));

        lin_addr = acb_pkg::A_W'(dyu) * acb_pkg::A_W'(stride) + acb_pkg::A_W'(dxu);

        o_dest.in_frame = visible && (lin_addr < acb_pkg::FB_DEPTH);
        o_dest.addr     = acb_pkg::ADDR_W'(lin_addr);

        last = (acb_pkg::ES_W'(row_e) == es - 1'b1) && (acb_pkg::ES_W'(col_e) == es - 1'b1);
        o_dest.last = last;

        // Row-major advance, wrap at the final pixel
        if (last) begin
            n_row = '0;
            n_col = '0;
        end else if (acb_pkg::ES_W'(col_e) + 1'b1 >= es) begin
            n_row = row_e + 1'b1;
            n_col = '0;
        end else begin
            n_row = row_e;
            n_col = col_e + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_advance) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

### rtl/acb_frame_ram.sv
// Framebuffer store: one write port, one read port with registered read data.
// Depends on acb_pkg for depth and pixel width. Contents undefined until written.
`timescale 1ns / 1ps

module acb_frame_ram (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic [acb_pkg::FB_AW-1:0]  i_raddr,
    output logic [acb_pkg::RGB_W-1:0]  o_rdata,
    input  logic                       i_we,
    input  logic [acb_pkg::FB_AW-1:0]  i_waddr,
    input  logic [acb_pkg::RGB_W-1:0]  i_wdata
);

    logic [acb_pkg::RGB_W-1:0] mem [acb_pkg::FB_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

### rtl/alpha_icon_blit_core.sv
// Alpha icon blitter top level: config registers, destination generator,
// framebuffer RAM and the read-blend-write pipeline with forwarding.
// Throughput: one transaction per cycle unless the output stalls; the RAM has separate
// read and write ports and stage 1 forwards its write data to a back-to-back blend of
// the same pixel. A result passes stage 1 (RAM read, then blend), then the output register.
// Reset clears the pipeline, icon counter and config; the framebuffer is not cleared.
// Depends on acb_pkg, acb_cfg_regs, acb_dest_gen and acb_frame_ram.
`timescale 1ns / 1ps

module alpha_icon_blit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acb_pkg::PADDR_W-1:0]   paddr,
    input  logic [acb_pkg::PDATA_W-1:0]   pwdata,
    output logic [acb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [acb_pkg::WORD_W-1:0]    i_pixel_word,
    input  logic [acb_pkg::ADDR_W-1:0]    i_load_address,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [acb_pkg::ADDR_W-1:0]    o_pixel_address,
    output logic [acb_pkg::RGB_W-1:0]     o_pixel_value,
    output logic                          o_wrote,
    output logic                          o_last_of_icon
);

    acb_pkg::t_cfg  cfg;
    acb_pkg::t_dest dest;

    logic                         accept;
    logic                         out_free;
    logic                         s1_free;
    logic                         is_blit;
    logic [acb_pkg::ALPHA_W-1:0]  alpha;
    logic                         n_write;
    logic                         n_blend;
    logic [acb_pkg::ADDR_W-1:0]   n_addr;
    logic                         n_last;
    logic                         n_fwd;
    logic [acb_pkg::RGB_W-1:0]    ram_rdata;
    logic                         ram_we;

    // Stage 1: RAM read in flight, blend and write back
    logic                         r_s1_valid;
    logic                         r_s1_write;
    logic                         r_s1_blend;
    logic [acb_pkg::ADDR_W-1:0]   r_s1_addr;
    logic [acb_pkg::RGB_W-1:0]    r_s1_rgb;
    logic [acb_pkg::ALPHA_W-1:0]  r_s1_alpha;
    logic                         r_s1_last;
    logic                         r_s1_fwd;
    logic [acb_pkg::RGB_W-1:0]    r_fwd_data;

    // Output register
    logic                         r_ov;
    logic [acb_pkg::ADDR_W-1:0]   r_o_addr;
    logic [acb_pkg::RGB_W-1:0]    r_o_value;
    logic                         r_o_wrote;
    logic                         r_o_last;

    logic [acb_pkg::WORD_W-1:0]   bg, fg, rb, g, rbf, gf, rb_d, g_d, rb_n, g_n;
    logic [acb_pkg::RGB_W-1:0]    blend_val;
    logic [acb_pkg::RGB_W-1:0]    wdata;

    acb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    acb_dest_gen u_dest (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (accept && is_blit),
        .o_dest    (dest)
    );

    acb_frame_ram u_ram (
        .i_clk   (i_clk),
        .i_re    (accept && n_blend),
        .i_raddr (dest.addr[acb_pkg::FB_AW-1:0]),
        .o_rdata (ram_rdata),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr[acb_pkg::FB_AW-1:0]),
        .i_wdata (wdata)
    );

    assign out_free   = !r_ov || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;
    assign ram_we     = r_s1_valid && out_free && r_s1_write;

    // Stage 0: classify the transaction
    always_comb begin
        is_blit = (i_func == acb_pkg::FUNC_BLIT);
        alpha   = i_pixel_word[acb_pkg::WORD_W-1 -: acb_pkg::ALPHA_W];
        if (is_blit) begin
            n_addr  = dest.in_frame ? dest.addr : '0;
            n_write = dest.in_frame && (alpha != acb_pkg::ALPHA_CLEAR);
            n_blend = n_write && (alpha != acb_pkg::ALPHA_OPAQUE);
            n_last  = dest.last;
        end else begin
            n_addr  = i_load_address;
            n_write = (i_load_address < acb_pkg::FB_DEPTH);
            n_blend = 1'b0;
            n_last  = 1'b0;
        end
        // Bypass the RAM when the pixel ahead writes the entry being read
        n_fwd = n_blend && r_s1_valid && r_s1_write && (r_s1_addr == dest.addr);
    end

    // Stage 1 blend: red/blue packed, green alone, 32-bit wrapping
    always_comb begin
        bg        = acb_pkg::WORD_W'(r_s1_fwd ? r_fwd_data : ram_rdata);
        fg        = acb_pkg::WORD_W'(r_s1_rgb);
        rb        = bg & acb_pkg::RB_MASK;
        g         = bg & acb_pkg::G_MASK;
        rbf       = fg & acb_pkg::RB_MASK;
        gf        = fg & acb_pkg::G_MASK;
        rb_d      = (rbf - rb) * acb_pkg::WORD_W'(r_s1_alpha);
        g_d       = (gf - g) * acb_pkg::WORD_W'(r_s1_alpha);
        rb_n      = rb + (rb_d >> acb_pkg::ALPHA_W);
        g_n       = g + (g_d >> acb_pkg::ALPHA_W);
        blend_val = acb_pkg::RGB_W'((rb_n & acb_pkg::RB_MASK) | (g_n & acb_pkg::G_MASK));
        wdata     = r_s1_blend ? blend_val : r_s1_rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_fwd   <= n_fwd;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_write <= n_write;
            r_s1_blend <= n_blend;
            r_s1_addr  <= n_addr;
            r_s1_rgb   <= i_pixel_word[acb_pkg::RGB_W-1:0];
            r_s1_alpha <= alpha;
            r_s1_last  <= n_last;
            r_fwd_data <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_s1_valid;
        end
        if (out_free && r_s1_valid) begin
            r_o_addr  <= r_s1_addr;
            r_o_value <= r_s1_write ? wdata : '0;
            r_o_wrote <= r_s1_write;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_value   = r_o_value;
    assign o_wrote         = r_o_wrote;
    assign o_last_of_icon  = r_o_last;

    // A stage 1 transaction blocked by the output holds in place
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1_addr))
        else $error("stage 1 transaction lost while output stalled");

    // Input stall only when stage 1 is occupied
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_ov)
        else $error("input stalled with free pipeline");

    // Forwarding only feeds blended pixels
    a_fwd_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_fwd |-> r_s1_blend)
        else $error("forward flag on a non-blend transaction");

    // A skipped or clipped pixel reports a zero value
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_wrote |-> o_pixel_value == '0)
        else $error("nonzero value on a result that did not write");

endmodule

### tb/sv/alpha_icon_blit_core_tb.sv
// Self-checking testbench for alpha_icon_blit_core: a directed table, then random
// phases of loads and icon blits under random idling and stalls, each checked against
// a predictor of the framebuffer and the icon counter. Depends on acb_pkg and the RTL.
`timescale 1ns / 1ps

module alpha_icon_blit_core_tb;

    import acb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_TARGET = 1850;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [RGB_W-1:0]  value;
        logic              wrote;
        logic              last;
    } blit_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e           kind;
        logic                func;
        logic [WORD_W-1:0]   word;
        logic [ADDR_W-1:0]   laddr;
        logic [REGIDX_W-1:0] reg_idx;
        logic [PDATA_W-1:0]  cfg_value;
        bit                  typed;
        blit_result_t        want;
    } dir_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_func = FUNC_LOAD;
    logic [WORD_W-1:0]    i_pixel_word = '0;
    logic [ADDR_W-1:0]    i_load_address = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [ADDR_W-1:0]    o_pixel_address;
    logic [RGB_W-1:0]     o_pixel_value;
    logic                 o_wrote;
    logic                 o_last_of_icon;

    alpha_icon_blit_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_pixel_word    (i_pixel_word),
        .i_load_address  (i_load_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_wrote         (o_wrote),
        .o_last_of_icon  (o_last_of_icon)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block: framebuffer, written flags, icon counter, registers
    logic [RGB_W-1:0]    fb_shadow [0:FB_DEPTH-1];
    bit                  fb_loaded [0:FB_DEPTH-1];
    logic [POS_W-1:0]    sh_left = '0;
    logic [POS_W-1:0]    sh_top = '0;
    logic [SIZE_W-1:0]   sh_size = ICON_SIZE_RST;
    logic [STRIDE_W-1:0] sh_stride = LINE_STRIDE_RST;
    logic [HEIGHT_W-1:0] sh_height = SCREEN_HEIGHT_RST;
    logic [CNT_W-1:0]    sh_row = '0;
    logic [CNT_W-1:0]    sh_col = '0;

    blit_result_t pixel_q [$];
    int           items_accepted = 0;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           tx_idle_pct = 30;
    int           rx_idle_pct = 30;
    int           rx_wait = 0;
    int           rx_count = 0;
    bit           hold_on = 1'b0;

    function automatic int clamp_to(int v, int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int sx10(logic [POS_W-1:0] v);
        return v[POS_W-1] ? int'(v) - 1024 : int'(v);
    endfunction

    function automatic int draw_wait(int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 18) : 0;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 20;
            2: return 60;
            default: return 100;
        endcase
    endfunction

    // Destination of the next blit, counter restart included, state untouched
    function automatic void blit_dest(output bit on_screen, output logic [ADDR_W-1:0] dest);
        int es, stride, height, r, c, dx, dy;
        es = clamp_to(int'(sh_size), MAX_ICON_SIZE);
        stride = clamp_to(int'(sh_stride), FB_WIDTH);
        height = clamp_to(int'(sh_height), FB_HEIGHT);
        r = sh_row;
        c = sh_col;
        if (r >= es || c >= es) begin
            r = 0;
            c = 0;
        end
        dx = sx10(sh_left) + c;
        dy = sx10(sh_top) + r;
        on_screen = (dx >= 0) && (dy >= 0) && (dx < stride) && (dy < height);
        dest = on_screen ? ADDR_W'(dy * stride + dx) : '0;
    endfunction

    // Red/blue packed and green alone, 32-bit wrapping
    function automatic logic [RGB_W-1:0] blend_rgb(logic [RGB_W-1:0] bg, logic [RGB_W-1:0] fg,
                                                   logic [ALPHA_W-1:0] alpha);
        logic [31:0] rb, g, rbf, gf, a;
        rb = {8'h00, bg} & RB_MASK;
        g = {8'h00, bg} & G_MASK;
        rbf = {8'h00, fg} & RB_MASK;
        gf = {8'h00, fg} & G_MASK;
        a = {24'h0, alpha};
        rb = rb + (((rbf - rb) * a) >> 8);
        g = g + (((gf - g) * a) >> 8);
        return RGB_W'((rb & RB_MASK) | (g & G_MASK));
    endfunction

    function automatic blit_result_t apply_item(logic f, logic [WORD_W-1:0] w,
                                                logic [ADDR_W-1:0] a);
        blit_result_t r;
        bit on;
        logic [ADDR_W-1:0] d;
        logic [ALPHA_W-1:0] alpha;
        int es;
        r = '0;
        if (f == FUNC_LOAD) begin
            r.addr = a;
            r.value = w[RGB_W-1:0];
            r.wrote = 1'b1;
            fb_shadow[a] = w[RGB_W-1:0];
            fb_loaded[a] = 1'b1;
        end else begin
            es = clamp_to(int'(sh_size), MAX_ICON_SIZE);
            blit_dest(on, d);
            if (sh_row >= es || sh_col >= es) begin
                sh_row = '0;
                sh_col = '0;
            end
            alpha = w[WORD_W-1:RGB_W];
            if (on) begin
                r.addr = d;
                if (alpha == ALPHA_OPAQUE) begin
                    r.value = w[RGB_W-1:0];
                    r.wrote = 1'b1;
                end else if (alpha != ALPHA_CLEAR) begin
                    r.value = blend_rgb(fb_shadow[d], w[RGB_W-1:0], alpha);
                    r.wrote = 1'b1;
                end
                if (r.wrote) begin
                    fb_shadow[d] = r.value;
                    fb_loaded[d] = 1'b1;
                end
            end
            if (sh_row == es - 1 && sh_col == es - 1) begin
                r.last = 1'b1;
                sh_row = '0;
                sh_col = '0;
            end else if (sh_col + 1 >= es) begin
                sh_col = '0;
                sh_row = sh_row + 1'b1;
            end else begin
                sh_col = sh_col + 1'b1;
            end
        end
        return r;
    endfunction

    // Offer one transaction, hold it until taken, then predict its result
    task automatic send_item(logic f, logic [WORD_W-1:0] w, logic [ADDR_W-1:0] a,
                             bit typed, blit_result_t want);
        int gap;
        blit_result_t predicted;
        gap = draw_wait(tx_idle_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_pixel_word <= w;
        i_load_address <= a;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_item(f, w, a);
        pixel_q.push_back(typed ? want : predicted);
        items_accepted++;
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [REGIDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ICON_LEFT:     sh_left = value[POS_W-1:0];
            REG_ICON_TOP:      sh_top = value[POS_W-1:0];
            REG_ICON_SIZE:     sh_size = value[SIZE_W-1:0];
            REG_LINE_STRIDE:   sh_stride = value[STRIDE_W-1:0];
            REG_SCREEN_HEIGHT: sh_height = value[HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // Load to a random address or onto the icon's next destination
    task automatic send_load_random();
        bit on;
        logic [ADDR_W-1:0] d;
        blit_dest(on, d);
        if (!on || $urandom_range(0, 1) == 0) d = ADDR_W'($urandom());
        send_item(FUNC_LOAD, $urandom(), d, 1'b0, '0);
    endtask

    task automatic send_blit_random();
        logic [WORD_W-1:0] w;
        bit on;
        logic [ADDR_W-1:0] d;
        w = $urandom();
        case ($urandom_range(0, 9))
            0, 1:    w[WORD_W-1:RGB_W] = ALPHA_CLEAR;
            2, 3, 4: w[WORD_W-1:RGB_W] = ALPHA_OPAQUE;
            5:       w[WORD_W-1:RGB_W] = 8'd1;
            6:       w[WORD_W-1:RGB_W] = 8'd254;
            default: ;
        endcase
        // a blend must never land on a pixel that was never written
        blit_dest(on, d);
        if (on && w[WORD_W-1:RGB_W] != ALPHA_CLEAR && w[WORD_W-1:RGB_W] != ALPHA_OPAQUE
                && !fb_loaded[d])
            send_item(FUNC_LOAD, $urandom(), d, 1'b0, '0);
        send_item(FUNC_BLIT, w, ADDR_W'($urandom()), 1'b0, '0);
    endtask

    function automatic logic [PDATA_W-1:0] rand_pos();
        logic [PDATA_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0: ;
            1: v[POS_W-1:0] = 10'h200;
            2: v[POS_W-1:0] = 10'h1FF;
            default: v[POS_W-1:0] = POS_W'($urandom_range(0, 208)) - 10'd8;
        endcase
        return v;
    endfunction

    function automatic logic [PDATA_W-1:0] rand_extent(int hi, int common_hi);
        logic [PDATA_W-1:0] v;
        v = $urandom();
        v[STRIDE_W-1:0] = '0;
        case ($urandom_range(0, 9))
            0: v[STRIDE_W-1:0] = '0;
            1: v[STRIDE_W-1:0] = STRIDE_W'($urandom_range(hi + 1, 2 * hi - 1));
            2: v[STRIDE_W-1:0] = STRIDE_W'(hi);
            default: v[STRIDE_W-1:0] = STRIDE_W'($urandom_range(1, common_hi));
        endcase
        return v;
    endfunction

    function automatic dir_row_t item_row(logic f, logic [WORD_W-1:0] w, logic [ADDR_W-1:0] a);
        dir_row_t r;
        r = '{kind: ROW_ITEM, func: f, word: w, laddr: a, reg_idx: '0, cfg_value: '0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic f, logic [WORD_W-1:0] w,
                                           logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] ea,
                                           logic [RGB_W-1:0] ev, logic ew, logic el);
        dir_row_t r;
        r = item_row(f, w, a);
        r.typed = 1'b1;
        r.want = {ea, ev, ew, el};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [REGIDX_W-1:0] idx, logic [PDATA_W-1:0] v);
        dir_row_t r;
        r = item_row(FUNC_LOAD, '0, '0);
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.cfg_value = v;
        return r;
    endfunction

    // Result side: random stalls, long hold-off from its own process
    always @(posedge i_clk) begin
        blit_result_t got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_pixel_address, o_pixel_value, o_wrote, o_last_of_icon};
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr %h value %h wrote %b last %b",
                             got.addr, got.value, got.wrote, got.last);
            end else begin
                want = pixel_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected addr %h value %h wrote %b last %b,",
                                  " got addr %h value %h wrote %b last %b"},
                                 want.addr, want.value, want.wrote, want.last,
                                 got.addr, got.value, got.wrote, got.last);
                end
            end
            rx_count++;
            if (rx_count % 50 == 0) rx_idle_pct = pick_idle_pct();
            rx_wait = draw_wait(rx_idle_pct);
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        i_out_stall <= hold_on || (rx_wait > 0);
    end

    initial begin
        int marks [2];
        marks = '{500, 1300};
        foreach (marks[k]) begin
            wait (items_accepted >= marks[k]);
            @(posedge i_clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("alpha_icon_blit_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        dir_row_t rows [$];
        int burst;

        // Reset-value geometry first, then clipping and clamping corners
        rows.push_back(typed_row(FUNC_LOAD, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'hFFFFFF, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_LOAD, 32'h00123456, 16'hFFFF,
                                 16'hFFFF, 24'h123456, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_LOAD, 32'hAB00FF00, 16'h0002,
                                 16'h0002, 24'h00FF00, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_LOAD, 32'h00000000, 16'h0003,
                                 16'h0003, 24'h000000, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFF89ABCD, 16'hFFFF,
                                 16'h0000, 24'h89ABCD, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'h00FFFFFF, 16'h0000,
                                 16'h0001, 24'h000000, 1'b0, 1'b0));
        rows.push_back(item_row(FUNC_BLIT, 32'h80FFFFFF, 16'h5555));
        rows.push_back(item_row(FUNC_BLIT, 32'h01FFFFFF, 16'hAAAA));
        // shrink the icon under a running counter, then clip on the left, right and top sides
        rows.push_back(cfg_row(REG_ICON_SIZE, 32'd1));
        rows.push_back(cfg_row(REG_ICON_LEFT, 32'h3FF));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b1));
        rows.push_back(cfg_row(REG_ICON_LEFT, 32'h1FF));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b1));
        rows.push_back(cfg_row(REG_ICON_LEFT, 32'h000));
        rows.push_back(cfg_row(REG_ICON_TOP, 32'h200));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b1));
        rows.push_back(cfg_row(REG_ICON_TOP, 32'h000));
        rows.push_back(cfg_row(REG_LINE_STRIDE, 32'd0));
        rows.push_back(cfg_row(REG_SCREEN_HEIGHT, 32'd0));
        rows.push_back(item_row(FUNC_BLIT, 32'hFEFFFFFF, 16'h0000));
        // saturated stride and height, icon on the right and bottom edges
        rows.push_back(cfg_row(REG_ICON_SIZE, 32'd2));
        rows.push_back(cfg_row(REG_LINE_STRIDE, 32'd511));
        rows.push_back(cfg_row(REG_SCREEN_HEIGHT, 32'd511));
        rows.push_back(cfg_row(REG_ICON_LEFT, 32'h0FF));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFF13579B, 16'h0000,
                                 16'h00FF, 24'h13579B, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'h80FFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'h00FFFFFF, 16'h0000,
                                 16'h01FF, 24'h000000, 1'b0, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b1));
        rows.push_back(cfg_row(REG_ICON_LEFT, 32'h000));
        rows.push_back(cfg_row(REG_ICON_TOP, 32'h0FF));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFF2468AC, 16'h0000,
                                 16'hFF00, 24'h2468AC, 1'b1, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'h00FFFFFF, 16'h0000,
                                 16'hFF01, 24'h000000, 1'b0, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b0));
        rows.push_back(typed_row(FUNC_BLIT, 32'hFFFFFFFF, 16'h0000,
                                 16'h0000, 24'h000000, 1'b0, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                drain();
                cfg_write(rows[k].reg_idx, rows[k].cfg_value);
            end else begin
                send_item(rows[k].func, rows[k].word, rows[k].laddr, rows[k].typed,
                          rows[k].want);
            end
        end

        while (items_accepted < RANDOM_TARGET) begin
            drain();
            cfg_write(REG_ICON_LEFT, rand_pos());
            cfg_write(REG_ICON_TOP, rand_pos());
            case ($urandom_range(0, 9))
                0: cfg_write(REG_ICON_SIZE, 32'd0);
                1: cfg_write(REG_ICON_SIZE, $urandom_range(MAX_ICON_SIZE + 1, 127));
                2: cfg_write(REG_ICON_SIZE, MAX_ICON_SIZE);
                default: cfg_write(REG_ICON_SIZE, $urandom_range(1, 10));
            endcase
            cfg_write(REG_LINE_STRIDE, rand_extent(FB_WIDTH, 64));
            cfg_write(REG_SCREEN_HEIGHT, rand_extent(FB_HEIGHT, 64));
            tx_idle_pct = pick_idle_pct();
            burst = $urandom_range(40, 160);
            repeat (burst) begin
                if ($urandom_range(0, 6) == 0) send_load_random();
                else send_blit_random();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("alpha_icon_blit_core_tb: done, clean");
        end else begin
            $display("alpha_icon_blit_core_tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/acb_pkg.sv
rtl/acb_cfg_regs.sv
rtl/acb_dest_gen.sv
rtl/acb_frame_ram.sv
rtl/alpha_icon_blit_core.sv
tb/sv/alpha_icon_blit_core_tb.sv
